// File: rtl/core/bwf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bwf_pkg: shared definitions for the fourth-order IIR filter core
// Formats, multiplier widths, register indexes, sequencer states and controls.
// ----------------------------------------------------------------------------
package bwf_pkg;

   localparam int SAMPLE_BITS     = 16;    // Q1.15 samples
   localparam int COEF_BITS       = 32;    // Q4.28 coefficients
   localparam int COEF_FRAC_BITS  = 28;
   localparam int FILTER_ORDER    = 4;
   localparam int PRIME_COUNT_DEF = 256;
   localparam int STATE_BITS      = 48;    // y and delay words
   localparam int HALF_BITS       = 16;    // coefficients go through the multiplier in halves
   localparam int NUM_SHIFT       = COEF_FRAC_BITS - HALF_BITS;
   localparam int ROUND_SHIFT     = 16;

   // shared multiplier: 48-bit signed by 17-bit signed
   localparam int MUL_A_BITS = STATE_BITS;
   localparam int MUL_B_BITS = HALF_BITS + 1;
   localparam int PROD_BITS  = MUL_A_BITS + MUL_B_BITS;

   localparam int HI_BITS      = STATE_BITS + HALF_BITS;   // y * coef / 2^16
   localparam int M_BITS       = HI_BITS - NUM_SHIFT;      // feedback term
   localparam int SUM_BITS     = M_BITS + 2;
   localparam int TAP_MAG_BITS = 4;
   localparam int BX_FULL_BITS = STATE_BITS + TAP_MAG_BITS;
   localparam int FB_IDX_BITS  = $clog2(FILTER_ORDER);
   localparam int TAP_BITS     = $clog2(FILTER_ORDER + 1);

   // binomial row of the numerator
   localparam logic [TAP_MAG_BITS-1:0] TAP_MAG [0:FILTER_ORDER] =
      '{4'd1, 4'd4, 4'd6, 4'd4, 4'd1};

   // register map
   localparam int CSR_INDEX_BITS = 3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MODE = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_GAIN = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_A1   = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_A4   = 3'd5;
   localparam logic signed [COEF_BITS-1:0] GAIN_RESET = 32'sh1000_0000;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_GLO,
      ST_GHI,
      ST_GSUM,
      ST_BX,
      ST_Y,
      ST_MLO,
      ST_MHI,
      ST_MSUM,
      ST_UPD,
      ST_DONE
   } state_type;

   typedef enum logic [1:0] {
      MUL_GAIN_LO,
      MUL_GAIN_HI,
      MUL_COEF_LO,
      MUL_COEF_HI
   } mul_sel_type;

   typedef struct packed {
      logic        ready;
      mul_sel_type mul_sel;
      logic        load_gain_lo;
      logic        load_coef_lo;
      logic        load_gx;
      logic        load_bx;
      logic        load_y;
      logic        load_m;
      logic        load_upd;
      logic        finish;
   } ctrl_type;

endpackage
`default_nettype wire

// File: rtl/core/bwf_mul.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bwf_mul: shared signed multiplier
// One registered 48 x 17 signed product per cycle, ready the cycle after its operands.
// ----------------------------------------------------------------------------
module bwf_mul
   import bwf_pkg::*;
(
   input  wire logic                          clock,
   input  wire logic signed [MUL_A_BITS-1:0]  op_a,
   input  wire logic signed [MUL_B_BITS-1:0]  op_b,
   output logic signed [PROD_BITS-1:0]        product
);

   logic signed [PROD_BITS-1:0] prod_ff;

   always_ff @(posedge clock) begin
      prod_ff <= op_a * op_b;
   end

   assign product = prod_ff;

endmodule
`default_nettype wire

// File: rtl/core/butterworth_iir_filter_order4_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// butterworth_iir_filter_order4_core: fourth-order IIR, transposed form II
// Binomial numerator scaled by a gain, programmable denominator a1..a4.
// ----------------------------------------------------------------------------
// Usage:
//   req_*  one sample beat in (valid/ready); req_block_start clears the delay
//          words and runs the filter PRIME_COUNT extra times on that sample.
//   rsp_*  one filtered, rounded and saturated sample per request beat.
//   csr_*  register writes, taken on any cycle with csr_write_enable high;
//          write only while no sample is in flight; the core leaves this to the user.
// Sequence: one shared multiplier under a sequencer. A plain sample runs the
//   gain product (GLO, GHI, GSUM), the taps (BX), y (Y), four feedback taps
//   of MLO, MHI, MSUM and UPD each, then loads the output in DONE; req_ready
//   rises as the result is loaded, so no new sample is taken before the last
//   is through. A start beat adds PRIME_COUNT priming passes (Y and four taps).
// Stall: the result sits in an output register; a new request may run while
//   it waits, and the core only holds in its final state if the previous
//   result is still untaken when the next one is ready.
// Reset: registers to their defaults, delay words cleared, no result pending.
// ----------------------------------------------------------------------------
module butterworth_iir_filter_order4_core
   import bwf_pkg::*;
#(
   parameter int PRIME_COUNT = PRIME_COUNT_DEF
)(
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic signed [SAMPLE_BITS-1:0] req_sample_in,
   input  wire logic                          req_block_start,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic signed [SAMPLE_BITS-1:0]      rsp_sample_out,
   output logic                               rsp_clipped,
   input  wire logic                          csr_write_enable,
   input  wire logic [CSR_INDEX_BITS-1:0]     csr_index,
   input  wire logic [COEF_BITS-1:0]          csr_write_data
);

   localparam int CNT_BITS  = (PRIME_COUNT > 0) ? $clog2(PRIME_COUNT + 1) : 1;
   localparam int RND_BITS  = STATE_BITS + 1 - ROUND_SHIFT;
   localparam int BX_REP    = STATE_BITS + NUM_SHIFT - BX_FULL_BITS;
   localparam logic signed [STATE_BITS:0] ROUND_HALF =
      (STATE_BITS + 1)'(1) << (ROUND_SHIFT - 1);
   localparam logic signed [STATE_BITS-1:0] STATE_MAX = {1'b0, {(STATE_BITS-1){1'b1}}};
   localparam logic signed [STATE_BITS-1:0] STATE_MIN = {1'b1, {(STATE_BITS-1){1'b0}}};

   function automatic logic signed [STATE_BITS-1:0] sat_state(
      input logic signed [SUM_BITS-1:0] v
   );
      logic all_ones;
      logic all_zeros;
      all_ones  = &v[SUM_BITS-1:STATE_BITS-1];
      all_zeros = ~|v[SUM_BITS-1:STATE_BITS-1];
      if (all_ones || all_zeros) begin
         return v[STATE_BITS-1:0];
      end else if (v[SUM_BITS-1]) begin
         return STATE_MIN;
      end else begin
         return STATE_MAX;
      end
   endfunction

   // control
   state_type              state_ff, state_in;
   ctrl_type               ctrl;
   logic [TAP_BITS-1:0]    tap_ff, tap_in;
   logic [CNT_BITS-1:0]    prime_ff, prime_in;
   logic                   req_take;
   logic                   last_tap;
   logic                   out_load;

   // registers
   logic                          mode_ff;
   logic signed [COEF_BITS-1:0]   gain_ff;
   logic signed [COEF_BITS-1:0]   fb_ff [0:FILTER_ORDER-1];

   // datapath
   logic signed [SAMPLE_BITS-1:0] x_ff;
   logic signed [STATE_BITS-1:0]  lo_ff;
   logic signed [STATE_BITS-1:0]  gx_ff;
   logic signed [STATE_BITS-1:0]  bx_ff [0:FILTER_ORDER];
   logic signed [STATE_BITS-1:0]  y_ff;
   logic signed [M_BITS-1:0]      m_ff;
   logic signed [STATE_BITS-1:0]  dq_ff [0:FILTER_ORDER-1];
   logic signed [STATE_BITS-1:0]  dq_in [0:FILTER_ORDER-1];

   logic                          rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_BITS-1:0] rsp_sample_ff;
   logic                          rsp_clip_ff;

   logic [FB_IDX_BITS-1:0]        fb_idx;
   logic signed [COEF_BITS-1:0]   coef_sel;
   logic signed [MUL_A_BITS-1:0]  mul_a;
   logic signed [MUL_B_BITS-1:0]  mul_b;
   logic signed [PROD_BITS-1:0]   mul_p;

   logic signed [STATE_BITS-1:0]  gx_sum;
   logic [BX_FULL_BITS-1:0]       bx_scaled [0:FILTER_ORDER];
   logic signed [STATE_BITS-1:0]  bx_calc [0:FILTER_ORDER];
   logic signed [SUM_BITS-1:0]    y_sum;
   logic [HI_BITS-1:0]            hi_sum;
   logic signed [SUM_BITS-1:0]    upd_sum;
   logic signed [STATE_BITS:0]    r_sum;
   logic [RND_BITS-1:0]           r_val;
   logic                          r_ovf;

   // ---------------------------------------------------------------- sequencer
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_GLO;
         end
         ST_GLO:  state_in = ST_GHI;
         ST_GHI:  state_in = ST_GSUM;
         ST_GSUM: state_in = ST_BX;
         ST_BX:   state_in = ST_Y;
         ST_Y:    state_in = ST_MLO;
         ST_MLO:  state_in = ST_MHI;
         ST_MHI:  state_in = ST_MSUM;
         ST_MSUM: state_in = ST_UPD;
         ST_UPD: begin
            if (!last_tap) begin
               state_in = ST_MLO;
            end else if (prime_ff != '0) begin
               state_in = ST_Y;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      ctrl         = '0;
      ctrl.mul_sel = MUL_COEF_LO;
      case (state_ff)
         ST_IDLE: ctrl.ready = 1'b1;
         ST_GLO:  ctrl.mul_sel = MUL_GAIN_LO;
         ST_GHI: begin
            ctrl.mul_sel      = MUL_GAIN_HI;
            ctrl.load_gain_lo = 1'b1;
         end
         ST_GSUM: ctrl.load_gx = 1'b1;
         ST_BX:   ctrl.load_bx = 1'b1;
         ST_Y:    ctrl.load_y  = 1'b1;
         ST_MLO:  ctrl.mul_sel = MUL_COEF_LO;
         ST_MHI: begin
            ctrl.mul_sel      = MUL_COEF_HI;
            ctrl.load_coef_lo = 1'b1;
         end
         ST_MSUM: ctrl.load_m   = 1'b1;
         ST_UPD:  ctrl.load_upd = 1'b1;
         ST_DONE: ctrl.finish   = 1'b1;
         default: ctrl.ready    = 1'b0;
      endcase
   end

   assign req_take = req_valid && ctrl.ready;
   assign last_tap = (tap_ff == TAP_BITS'(FILTER_ORDER));
   assign out_load = ctrl.finish && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      tap_in   = tap_ff;
      prime_in = prime_ff;
      if (req_take) begin
         prime_in = req_block_start ? CNT_BITS'(PRIME_COUNT) : '0;
      end
      if (ctrl.load_y) begin
         tap_in = TAP_BITS'(1);
      end
      if (ctrl.load_upd) begin
         tap_in = tap_ff + 1'b1;
         if (last_tap && prime_ff != '0) prime_in = prime_ff - 1'b1;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         tap_ff       <= '0;
         prime_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         tap_ff       <= tap_in;
         prime_ff     <= prime_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // ---------------------------------------------------------------- registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= 1'b0;
         gain_ff <= GAIN_RESET;
         for (int i = 0; i < FILTER_ORDER; i++) fb_ff[i] <= '0;
      end else if (csr_write_enable) begin
         case (csr_index) inside
            CSR_MODE:        mode_ff <= csr_write_data[0];
            CSR_GAIN:        gain_ff <= csr_write_data;
            [CSR_A1:CSR_A4]: fb_ff[FB_IDX_BITS'(csr_index - CSR_A1)] <= csr_write_data;
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------- multiplier
   assign fb_idx   = FB_IDX_BITS'(tap_ff - 1'b1);
   assign coef_sel = (ctrl.mul_sel == MUL_GAIN_LO || ctrl.mul_sel == MUL_GAIN_HI) ?
                     gain_ff : fb_ff[fb_idx];

   always_comb begin
      if (ctrl.mul_sel == MUL_GAIN_LO || ctrl.mul_sel == MUL_GAIN_HI) begin
         mul_a = {{(MUL_A_BITS-SAMPLE_BITS){x_ff[SAMPLE_BITS-1]}}, x_ff};
      end else begin
         mul_a = y_ff;
      end
      // low half unsigned, high half signed
      if (ctrl.mul_sel == MUL_GAIN_LO || ctrl.mul_sel == MUL_COEF_LO) begin
         mul_b = $signed({1'b0, coef_sel[HALF_BITS-1:0]});
      end else begin
         mul_b = $signed({coef_sel[COEF_BITS-1], coef_sel[COEF_BITS-1:HALF_BITS]});
      end
   end

   bwf_mul u_mul (
      .clock   (clock),
      .op_a    (mul_a),
      .op_b    (mul_b),
      .product (mul_p)
   );

   // ---------------------------------------------------------------- datapath
   assign gx_sum = $signed({mul_p[STATE_BITS-HALF_BITS-1:0], {HALF_BITS{1'b0}}}) + lo_ff;

   // numerator terms: gain*x times binomial tap, odd taps negated for highpass
   always_comb begin
      for (int i = 0; i <= FILTER_ORDER; i++) begin
         bx_scaled[i] = {{TAP_MAG_BITS{gx_ff[STATE_BITS-1]}}, gx_ff}
                        * BX_FULL_BITS'(TAP_MAG[i]);
         if (mode_ff && i[0]) bx_scaled[i] = -bx_scaled[i];
         bx_calc[i] = $signed({{BX_REP{bx_scaled[i][BX_FULL_BITS-1]}},
                               bx_scaled[i][BX_FULL_BITS-1:NUM_SHIFT]});
      end
   end

   assign y_sum   = SUM_BITS'(bx_ff[0]) + SUM_BITS'(dq_ff[0]);
   assign hi_sum  = mul_p[HI_BITS-1:0] + HI_BITS'(lo_ff);
   assign upd_sum = SUM_BITS'(bx_ff[tap_ff]) + SUM_BITS'(dq_ff[0]) - SUM_BITS'(m_ff);

   // delay words shift one place per step; y pushes a zero in behind d[N-1]
   always_comb begin
      for (int i = 0; i < FILTER_ORDER; i++) dq_in[i] = dq_ff[i];
      if (req_take && req_block_start) begin
         for (int i = 0; i < FILTER_ORDER; i++) dq_in[i] = '0;
      end else if (ctrl.load_y || ctrl.load_upd) begin
         for (int i = 0; i < FILTER_ORDER - 1; i++) dq_in[i] = dq_ff[i+1];
         dq_in[FILTER_ORDER-1] = ctrl.load_y ? '0 : sat_state(upd_sum);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < FILTER_ORDER; i++) dq_ff[i] <= '0;
      end else begin
         for (int i = 0; i < FILTER_ORDER; i++) dq_ff[i] <= dq_in[i];
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) x_ff <= req_sample_in;
      if (ctrl.load_gain_lo) lo_ff <= mul_p[STATE_BITS-1:0];
      if (ctrl.load_coef_lo) lo_ff <= mul_p[STATE_BITS+HALF_BITS-1:HALF_BITS];
      if (ctrl.load_gx) gx_ff <= gx_sum;
      if (ctrl.load_bx) begin
         for (int i = 0; i <= FILTER_ORDER; i++) bx_ff[i] <= bx_calc[i];
      end
      if (ctrl.load_y) y_ff <= sat_state(y_sum);
      if (ctrl.load_m) m_ff <= $signed(hi_sum[HI_BITS-1:NUM_SHIFT]);
   end

   // ---------------------------------------------------------------- output
   assign r_sum = (STATE_BITS + 1)'(y_ff) + ROUND_HALF;
   assign r_val = r_sum[STATE_BITS:ROUND_SHIFT];
   assign r_ovf = !(&r_val[RND_BITS-1:SAMPLE_BITS-1]) && (|r_val[RND_BITS-1:SAMPLE_BITS-1]);

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_clip_ff <= r_ovf;
         if (!r_ovf) begin
            rsp_sample_ff <= $signed(r_val[SAMPLE_BITS-1:0]);
         end else if (r_val[RND_BITS-1]) begin
            rsp_sample_ff <= {1'b1, {(SAMPLE_BITS-1){1'b0}}};
         end else begin
            rsp_sample_ff <= {1'b0, {(SAMPLE_BITS-1){1'b1}}};
         end
      end
   end

   assign req_ready      = ctrl.ready;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_sample_out = rsp_sample_ff;
   assign rsp_clipped    = rsp_clip_ff;

   // ---------------------------------------------------------------- checks
   a_take_starts: assert property (@(posedge clock) disable iff (reset)
      req_take |=> (state_ff == ST_GLO))
      else $error("accepted beat did not start the gain product");

   a_prime_bound: assert property (@(posedge clock) disable iff (reset)
      prime_ff <= CNT_BITS'(PRIME_COUNT))
      else $error("priming count above its load value");

   a_done_primed: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE) |-> (prime_ff == '0))
      else $error("result reached with priming passes left");

   a_tap_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MLO || state_ff == ST_MHI || state_ff == ST_MSUM ||
       state_ff == ST_UPD) |-> (tap_ff >= TAP_BITS'(1) && tap_ff <= TAP_BITS'(FILTER_ORDER)))
      else $error("feedback tap index out of range");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_DONE))
      else $error("result raised outside the final state");

endmodule
`default_nettype wire
